/* rtl/trivium_stream_cipher_top_macros.svh */
// assertion macros of the trivium modules, included by trivium_ctrl
`ifndef TRIVIUM_STREAM_CIPHER_TOP_MACROS_SVH
`define TRIVIUM_STREAM_CIPHER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define TSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/trivium_pkg.sv */
// types, constants and round functions of the trivium keystream block
package trivium_pkg;

	localparam int STATE_BITS      = 288;
	localparam int WARMUP_ROUNDS   = 1152;
	localparam int ROUNDS_PER_STEP = 8;
	localparam int KEY_BITS        = 80;
	localparam int IV_BASE         = 93;
	localparam int CFG_W           = 64;
	localparam int HIGH_W          = KEY_BITS - CFG_W;
	localparam int CNT_RAW_W       = $clog2(WARMUP_ROUNDS + 1);
	localparam int CNT_W           = (CNT_RAW_W > 4) ? CNT_RAW_W : 4;

	// opcodes of an input item
	localparam logic OP_INIT  = 1'b0;
	localparam logic OP_CRYPT = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
	localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
	localparam logic [1:0] CFG_IV_LOW   = 2'd2;
	localparam logic [1:0] CFG_IV_HIGH  = 2'd3;

	typedef struct packed {
		logic load;   // load key and iv into the state
		logic crypt;  // eight rounds and register the output byte
		logic warm8;  // eight warm-up rounds
		logic warm1;  // one warm-up round
	} cmd_t;

	typedef struct packed {
		logic                  z;
		logic [STATE_BITS-1:0] s;
	} round_t;

	// one trivium round, s_i held at bit i-1
	function automatic round_t trivium_round(input logic [STATE_BITS-1:0] s);
		logic t1;
		logic t2;
		logic t3;
		round_t r;
		t1 = s[65] ^ s[92];
		t2 = s[161] ^ s[176];
		t3 = s[242] ^ s[287];
		r.z = t1 ^ t2 ^ t3;
		t1 = t1 ^ (s[90] & s[91]) ^ s[170];
		t2 = t2 ^ (s[174] & s[175]) ^ s[263];
		t3 = t3 ^ (s[285] & s[286]) ^ s[68];
		r.s = {s[286:177], t2, s[175:93], t1, s[91:0], t3};
		return r;
	endfunction

	// initial state from key and iv, bit 1 of each in the msb
	function automatic logic [STATE_BITS-1:0] load_state(input logic [KEY_BITS-1:0] key,
		input logic [KEY_BITS-1:0] iv);
		logic [STATE_BITS-1:0] s;
		s = '0;
		for (int i = 0; i < KEY_BITS; i++) begin
			s[i]           = key[KEY_BITS-1-i];
			s[IV_BASE + i] = iv[KEY_BITS-1-i];
		end
		s[STATE_BITS-3] = 1'b1;
		s[STATE_BITS-2] = 1'b1;
		s[STATE_BITS-1] = 1'b1;
		return s;
	endfunction

endpackage

/* rtl/trivium_stream_cipher_top.sv */
// top level of the trivium keystream block
// Trivium stream cipher, one byte per data item. Write the key and iv through the
// configuration port (index 0 key_low, 1 key_high, 2 iv_low, 3 iv_high, high parts
// in cfg_data[15:0], key bit 1 and iv bit 1 in the msb of the high parts); the
// port is always ready and writes take effect at the next init. An init item
// (opcode 0) loads the state when it is taken and then runs the warm-up
// (1152 rounds run as eight per clock, any remainder one per clock); item_stall
// is high for the whole warm-up and init gives no result. A data item (opcode 1)
// runs eight unrolled rounds combinationally, so bytes stream at one per clock
// while results are not stalled; data_out is data_byte xor the keystream, first
// keystream bit in bit 0. The result sits in an output register, and a new item
// is taken in the same cycle the previous result transfers. Before any init the
// state is all zeros, so data passes through unchanged.
module trivium_stream_cipher_top import trivium_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	// input items
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        opcode,
	input  logic [ROUNDS_PER_STEP-1:0]  data_byte,
	// results
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [ROUNDS_PER_STEP-1:0]  data_out,
	// configuration writes
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [CFG_W-1:0]            cfg_data
);

	cmd_t cmd;

	// writes must come only while idle, which the block does not enforce; no back-pressure
	assign cfg_ready = 1'b1;

	// sequencing: accept, warm-up count, result valid
	trivium_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.opcode       (opcode),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	// state register, round logic and output byte
	trivium_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.data_byte (data_byte),
		.data_out  (data_out)
	);

endmodule

/* rtl/trivium_dp.sv */
// trivium datapath: key and iv registers, cipher state, output byte
module trivium_dp import trivium_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic [ROUNDS_PER_STEP-1:0]   data_byte,
	output logic [ROUNDS_PER_STEP-1:0]   data_out
);

	logic [CFG_W-1:0]            key_low_q;
	logic [HIGH_W-1:0]           key_high_q;
	logic [CFG_W-1:0]            iv_low_q;
	logic [HIGH_W-1:0]           iv_high_q;
	logic [STATE_BITS-1:0]       state_q;
	logic [ROUNDS_PER_STEP-1:0]  data_out_q;
	logic [STATE_BITS-1:0]       state8;
	logic [STATE_BITS-1:0]       state1;
	logic [ROUNDS_PER_STEP-1:0]  ks;
	round_t                      round1;

	// eight chained rounds, first keystream bit in bit 0
	always_comb begin
		round_t r;
		r.s = state_q;
		r.z = 1'b0;
		ks  = '0;
		for (int k = 0; k < ROUNDS_PER_STEP; k++) begin
			r     = trivium_round(r.s);
			ks[k] = r.z;
		end
		state8 = r.s;
	end

	assign round1 = trivium_round(state_q);
	assign state1 = round1.s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			iv_low_q   <= '0;
			iv_high_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				CFG_KEY_HIGH: key_high_q <= cfg_data[HIGH_W-1:0];
				CFG_IV_LOW:   iv_low_q   <= cfg_data;
				CFG_IV_HIGH:  iv_high_q  <= cfg_data[HIGH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cmd.load) begin
			state_q <= load_state({key_high_q, key_low_q}, {iv_high_q, iv_low_q});
		end else if (cmd.crypt || cmd.warm8) begin
			state_q <= state8;
		end else if (cmd.warm1) begin
			state_q <= state1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_out_q <= '0;
		end else if (cmd.crypt) begin
			data_out_q <= data_byte ^ ks;
		end
	end

	assign data_out = data_out_q;

endmodule

/* rtl/trivium_ctrl.sv */
// trivium controller: handshakes and warm-up sequencing
`include "trivium_stream_cipher_top_macros.svh"
module trivium_ctrl import trivium_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic opcode,
	output logic item_stall,
	output logic result_valid,
	input  logic result_stall,
	output cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WARM = 1'b1;
	localparam logic [CNT_W-1:0] WARM_START = CNT_W'(WARMUP_ROUNDS);
	localparam logic [CNT_W-1:0] STEP_LEN   = CNT_W'(ROUNDS_PER_STEP);
	localparam logic [CNT_W-1:0] ONE_LEN    = CNT_W'(1);

	logic             state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             result_valid_q;
	logic             accept;
	logic [CNT_W-1:0] cnt_next;

	assign item_stall = (state_q != ST_IDLE) || (result_valid_q && result_stall);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		cmd       = '0;
		cmd.load  = accept && (opcode == OP_INIT);
		cmd.crypt = accept && (opcode == OP_CRYPT);
		cmd.warm8 = (state_q == ST_WARM) && (cnt_q >= STEP_LEN);
		cmd.warm1 = (state_q == ST_WARM) && (cnt_q < STEP_LEN);
	end

	assign cnt_next = cmd.warm8 ? (cnt_q - STEP_LEN) : (cnt_q - ONE_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_WARM;
						cnt_q   <= WARM_START;
					end
				end
				ST_WARM: begin
					cnt_q <= cnt_next;
					if (cnt_next == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.crypt) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;

	`TSC_ASSERT_NOW(a_warm_blocks_input, state_q == ST_WARM, item_stall, "item taken during warm-up")
	`TSC_ASSERT_NOW(a_warm_count_live, state_q == ST_WARM, cnt_q != '0, "warm-up count ran out")
	`TSC_ASSERT_NEXT(a_init_starts_warm, cmd.load, state_q == ST_WARM, "init did not start warm-up")
	`TSC_ASSERT_NEXT(a_crypt_gives_result, cmd.crypt, result_valid_q, "data item gave no result")

endmodule

/* tb/trivium_stream_cipher_top_tb.sv */
// self-checking testbench of the trivium keystream block, directed table then random phases
module trivium_stream_cipher_top_tb;
	import trivium_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// long enough for the load and warm-up of an init, with room to spare
	localparam int SETTLE_CYCLES = 200;
	// directed rows plus the random phases, counted in input items
	localparam int TOTAL_ITEMS = 1425;
	localparam int PLAN_ROWS = 26;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic        opcode;
	logic [7:0]  data_byte;
	logic        result_valid;
	logic        result_stall;
	logic [7:0]  data_out;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	trivium_stream_cipher_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.data_out     (data_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor: the cipher state kept as its three shift registers
	// reg_a holds s1..s93, reg_b s94..s177, reg_c s178..s288, lowest s in bit 0
	// ------------------------------------------------------------------
	logic [92:0]  reg_a;
	logic [83:0]  reg_b;
	logic [110:0] reg_c;

	// shadow copies of the key and iv registers, as the block latches them
	logic [63:0] key_lo;
	logic [15:0] key_hi;
	logic [63:0] iv_lo;
	logic [15:0] iv_hi;

	// ciphertext bytes still owed by the block, oldest first
	logic [7:0] want_bytes [$];

	int  fail_count = 0;
	int  items_sent = 0;
	bit  tx_busy = 1'b1;
	bit  rx_busy = 1'b1;

	// one round: returns the keystream bit and advances the three registers
	function automatic logic step_round();
		logic fb_a;
		logic fb_b;
		logic fb_c;
		logic z;
		fb_a = reg_a[65] ^ reg_a[92];
		fb_b = reg_b[68] ^ reg_b[83];
		fb_c = reg_c[65] ^ reg_c[110];
		z = fb_a ^ fb_b ^ fb_c;
		// nonlinear feedback; each register feeds the next one round the ring
		fb_a = fb_a ^ (reg_a[90] & reg_a[91]) ^ reg_b[77];
		fb_b = fb_b ^ (reg_b[81] & reg_b[82]) ^ reg_c[86];
		fb_c = fb_c ^ (reg_c[108] & reg_c[109]) ^ reg_a[68];
		reg_a = {reg_a[91:0], fb_c};
		reg_b = {reg_b[82:0], fb_a};
		reg_c = {reg_c[109:0], fb_b};
		return z;
	endfunction

	// key into s1..s80 and iv into s94..s173, bit 1 of each being the msb, then the warm-up rounds
	function automatic void warm_up();
		logic [79:0] key80;
		logic [79:0] iv80;
		key80 = {key_hi, key_lo};
		iv80 = {iv_hi, iv_lo};
		reg_a = '0;
		reg_b = '0;
		reg_c = '0;
		for (int i = 0; i < 80; i++) begin
			reg_a[i] = key80[79 - i];
			reg_b[i] = iv80[79 - i];
		end
		reg_c[110:108] = 3'b111;
		for (int r = 0; r < WARMUP_ROUNDS; r++)
			void'(step_round());
	endfunction

	// eight rounds, first keystream bit into bit 0
	function automatic logic [7:0] cipher_byte(input logic [7:0] plain);
		logic [7:0] ks;
		for (int i = 0; i < 8; i++)
			ks[i] = step_round();
		return plain ^ ks;
	endfunction

	// only the first ten failures are printed, the rest just counted
	function automatic void flag_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t ns: %s", $realtime, what);
	endfunction

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------

	// present one item after a random gap (none when tx_busy is clear) and hold it until the transfer
	task automatic send_item(input logic op, input logic [7:0] b, input bit known,
		input logic [7:0] typed);
		int gap;
		logic [7:0] predicted;
		gap = tx_busy ? $urandom_range(0, 12) : 0;
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		opcode     <= op;
		data_byte  <= b;
		do begin
			@(posedge clk);
		end while (item_stall);
		// transfer taken at this edge, update the predictor in item order
		if (op == OP_INIT) begin
			warm_up();
		end else begin
			predicted = cipher_byte(b);
			// the state still advances on typed rows, only the expectation differs
			want_bytes.push_back(known ? typed : predicted);
		end
		items_sent++;
	endtask

	// one configuration transfer; it waits for ready, which the port holds high
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (idx)
			CFG_KEY_LOW: begin
				key_lo = val;
			end
			CFG_KEY_HIGH: begin
				key_hi = val[15:0];
			end
			CFG_IV_LOW: begin
				iv_lo = val;
			end
			CFG_IV_HIGH: begin
				iv_hi = val[15:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop valid, wait for every owed byte, then let a possible warm-up finish
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (want_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------
	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  idx;
		logic [63:0] value;
		logic        op;
		logic [7:0]  byte_in;
		logic        known;   // typed expectation below is used
		logic [7:0]  typed;
	} plan_row_t;

	plan_row_t plan [0:PLAN_ROWS-1] = '{
		// before any init the state is all zero, so bytes pass straight through
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_CRYPT, 8'h00, 1'b1, 8'h00},
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_CRYPT, 8'hFF, 1'b1, 8'hFF},
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_CRYPT, 8'hA5, 1'b1, 8'hA5},
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_CRYPT, 8'h5A, 1'b1, 8'h5A},
		// init with the reset key and iv, all zero
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_INIT,  8'hC3, 1'b0, 8'h00},
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_CRYPT, 8'h00, 1'b0, 8'h00},
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_CRYPT, 8'hFF, 1'b0, 8'h00},
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_CRYPT, 8'h3C, 1'b0, 8'h00},
		// all-ones key and iv, junk above bit 15 on the high parts
		'{ROW_CFG, CFG_KEY_LOW,  64'hFFFF_FFFF_FFFF_FFFF, OP_CRYPT, 8'h00, 1'b0, 8'h00},
		'{ROW_CFG, CFG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, OP_CRYPT, 8'h00, 1'b0, 8'h00},
		'{ROW_CFG, CFG_IV_LOW,   64'hFFFF_FFFF_FFFF_FFFF, OP_CRYPT, 8'h00, 1'b0, 8'h00},
		'{ROW_CFG, CFG_IV_HIGH,  64'hFFFF_FFFF_FFFF_FFFF, OP_CRYPT, 8'h00, 1'b0, 8'h00},
		// new key not yet loaded, keystream continues from the zero-key state
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_CRYPT, 8'h00, 1'b0, 8'h00},
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_INIT,  8'h00, 1'b0, 8'h00},
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_CRYPT, 8'h00, 1'b0, 8'h00},
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_CRYPT, 8'hFF, 1'b0, 8'h00},
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_CRYPT, 8'h81, 1'b0, 8'h00},
		// mixed pattern, single bits at both ends of the iv
		'{ROW_CFG, CFG_KEY_LOW,  64'h0123_4567_89AB_CDEF, OP_CRYPT, 8'h00, 1'b0, 8'h00},
		'{ROW_CFG, CFG_KEY_HIGH, 64'hDEAD_BEEF_0000_8001, OP_CRYPT, 8'h00, 1'b0, 8'h00},
		'{ROW_CFG, CFG_IV_LOW,   64'h8000_0000_0000_0001, OP_CRYPT, 8'h00, 1'b0, 8'h00},
		'{ROW_CFG, CFG_IV_HIGH,  64'h0000_0000_0000_8000, OP_CRYPT, 8'h00, 1'b0, 8'h00},
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_INIT,  8'hFF, 1'b0, 8'h00},
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_CRYPT, 8'h00, 1'b0, 8'h00},
		// init back to back with data, restarts the same keystream
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_INIT,  8'h00, 1'b0, 8'h00},
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_CRYPT, 8'h00, 1'b0, 8'h00},
		'{ROW_ITEM, CFG_KEY_LOW, 64'd0, OP_CRYPT, 8'hFF, 1'b0, 8'h00}
	};

	// ------------------------------------------------------------------
	// receiver side: random stall, check each result transfer
	// ------------------------------------------------------------------
	initial begin : result_sink
		int hold;
		logic [7:0] owed;
		result_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			hold = rx_busy ? $urandom_range(0, 12) : 0;
			repeat (hold) begin
				@(negedge clk);
				result_stall <= 1'b1;
			end
			@(negedge clk);
			result_stall <= 1'b0;
			do begin
				@(posedge clk);
			end while (!result_valid);
			// transfer at this edge
			if (want_bytes.size() == 0) begin
				flag_failure($sformatf("unexpected result data_out=%02h", data_out));
			end else begin
				owed = want_bytes.pop_front();
				if (data_out !== owed)
					flag_failure($sformatf("data_out expected %02h got %02h", owed, data_out));
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [1:0]  reg_ids [0:3];
		logic [63:0] val;
		logic [7:0]  b;
		bit          after_cfg;
		int          run_len;

		reg_ids = '{CFG_KEY_LOW, CFG_KEY_HIGH, CFG_IV_LOW, CFG_IV_HIGH};

		// every input known from time zero
		arst_n     = 1'b0;
		item_valid = 1'b0;
		opcode     = OP_CRYPT;
		data_byte  = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_KEY_LOW;
		cfg_data   = '0;

		// predictor matches the reset state
		reg_a  = '0;
		reg_b  = '0;
		reg_c  = '0;
		key_lo = '0;
		key_hi = '0;
		iv_lo  = '0;
		iv_hi  = '0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed table, config rows only once the block has gone quiet
		after_cfg = 1'b1;
		for (int r = 0; r < PLAN_ROWS; r++) begin
			if (plan[r].kind == ROW_CFG) begin
				if (!after_cfg)
					drain();
				write_reg(plan[r].idx, plan[r].value);
				after_cfg = 1'b1;
			end else begin
				send_item(plan[r].op, plan[r].byte_in, plan[r].known, plan[r].typed);
				after_cfg = 1'b0;
			end
		end

		// random phases: new key and iv, usually an init, then a burst of bytes
		while (items_sent < TOTAL_ITEMS) begin
			drain();
			// about one phase in four runs a side with no idling at all
			tx_busy = ($urandom_range(0, 3) != 0);
			rx_busy = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < 4; k++) begin
				if ($urandom_range(0, 3) != 0) begin
					case ($urandom_range(0, 5))
						0: val = '0;
						1: val = '1;
						default: val = {$urandom, $urandom};
					endcase
					write_reg(reg_ids[k], val);
				end
			end
			// now and then skip the init so the old keystream runs on
			if ($urandom_range(0, 7) != 0)
				send_item(OP_INIT, 8'($urandom), 1'b0, 8'h00);
			run_len = $urandom_range(1, 48);
			for (int n = 0; n < run_len; n++) begin
				if ($urandom_range(0, 39) == 0) begin
					// stray re-init in the middle of a stream
					send_item(OP_INIT, 8'($urandom), 1'b0, 8'h00);
				end else begin
					case ($urandom_range(0, 9))
						0: b = 8'h00;
						1: b = 8'hFF;
						default: b = 8'($urandom);
					endcase
					send_item(OP_CRYPT, b, 1'b0, 8'h00);
				end
			end
		end

		// wait for every owed byte and let any warm-up settle
		drain();
		if (fail_count == 0)
			$display("trivium_stream_cipher_top: match");
		else
			$display("trivium_stream_cipher_top: mismatch");
		$finish;
	end

	// watchdog, well beyond the slowest correct run
	initial begin : watchdog
		#15_000_000;
		$display("trivium_stream_cipher_top: mismatch");
		$finish;
	end

endmodule
